// ----- rtl/core/potri_pkg.sv -----
// Shared constants, types and register indexes for the point to opinion
// triangle unit. No dependencies; files refer to it by scope or import it.
package potri_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 15;
   localparam int FIELD_W    = 16;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int WU_W       = SUM_W + 2;
   localparam int DEN_W      = PROD_W;
   localparam int REM_W      = DEN_W + 1;
   localparam int Q_W        = FRAC_BITS + 1;
   localparam int DIV_STAGES = FRAC_BITS + 1;
   localparam int CSR_IDX_W  = 3;

   localparam logic [FIELD_W-1:0] ONE_Q = FIELD_W'(1) << FRAC_BITS;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UNCERT_X    = 3'd0,
      CSR_UNCERT_Y    = 3'd1,
      CSR_DISBELIEF_X = 3'd2,
      CSR_DISBELIEF_Y = 3'd3,
      CSR_BELIEF_X    = 3'd4,
      CSR_BELIEF_Y    = 3'd5
   } csr_index_type;

   // Exact cross and dot products of one word
   typedef struct packed {
      logic signed [SUM_W-1:0] c;
      logic signed [SUM_W-1:0] wd;
      logic signed [SUM_W-1:0] wb;
      logic signed [SUM_W-1:0] n_ud;
      logic signed [SUM_W-1:0] l_ud;
      logic signed [SUM_W-1:0] n_ub;
      logic signed [SUM_W-1:0] l_ub;
      logic signed [SUM_W-1:0] n_db;
      logic signed [SUM_W-1:0] l_db;
      logic [FIELD_W-1:0]      prior;
   } potri_sums_type;

   // Numerators and shared denominator handed to the divider
   typedef struct packed {
      logic [DEN_W-1:0]   bn;
      logic [DEN_W-1:0]   dn;
      logic [DEN_W-1:0]   den;
      logic [FIELD_W-1:0] prior;
   } potri_frac_type;

   // One divider stage: partial quotients and remainders
   typedef struct packed {
      logic [REM_W-1:0]   rb;
      logic [REM_W-1:0]   rd;
      logic [Q_W-1:0]     qb;
      logic [Q_W-1:0]     qd;
      logic [DEN_W-1:0]   den;
      logic [FIELD_W-1:0] prior;
   } potri_div_type;

endpackage

// ----- rtl/core/potri_geom.sv -----
// Three-stage geometry front end: vertex offsets, products, sums.
// Depends on potri_pkg.
module potri_geom (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  logic                                   in_valid,
   input  logic signed [potri_pkg::COORD_BITS-1:0] point_x,
   input  logic signed [potri_pkg::COORD_BITS-1:0] point_y,
   input  logic [potri_pkg::FIELD_W-1:0]          prior_rate,
   input  logic signed [potri_pkg::COORD_BITS-1:0] ux,
   input  logic signed [potri_pkg::COORD_BITS-1:0] uy,
   input  logic signed [potri_pkg::COORD_BITS-1:0] dx,
   input  logic signed [potri_pkg::COORD_BITS-1:0] dy,
   input  logic signed [potri_pkg::COORD_BITS-1:0] bx,
   input  logic signed [potri_pkg::COORD_BITS-1:0] by,
   output logic                                   out_valid,
   output potri_pkg::potri_sums_type              out_sums
);
   localparam int DW = potri_pkg::DIFF_W;
   localparam int PW = potri_pkg::PROD_W;
   localparam int SW = potri_pkg::SUM_W;

   logic signed [DW-1:0] v0x_ff, v0y_ff, v1x_ff, v1y_ff, ex_ff, ey_ff;
   logic signed [DW-1:0] v2x_ff, v2y_ff, fx_ff, fy_ff;
   logic [potri_pkg::FIELD_W-1:0] prior1_ff, prior2_ff, prior_in;
   logic v1_ff, v2_ff, v3_ff;

   logic signed [PW-1:0] c0_ff, c1_ff, wd0_ff, wd1_ff, wb0_ff, wb1_ff;
   logic signed [PW-1:0] nud0_ff, nud1_ff, lud0_ff, lud1_ff;
   logic signed [PW-1:0] nub0_ff, nub1_ff, lub0_ff, lub1_ff;
   logic signed [PW-1:0] ndb0_ff, ndb1_ff, ldb0_ff, ldb1_ff;

   potri_pkg::potri_sums_type sums_ff, sums_in;

   // Clamp the base rate to one
   assign prior_in = (prior_rate > potri_pkg::ONE_Q) ? potri_pkg::ONE_Q : prior_rate;

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Stage 1: offsets from the corners
   always_ff @(posedge clock) begin
      if (enable) begin
         v0x_ff    <= DW'(dx) - DW'(ux);
         v0y_ff    <= DW'(dy) - DW'(uy);
         v1x_ff    <= DW'(bx) - DW'(ux);
         v1y_ff    <= DW'(by) - DW'(uy);
         ex_ff     <= DW'(bx) - DW'(dx);
         ey_ff     <= DW'(by) - DW'(dy);
         v2x_ff    <= DW'(point_x) - DW'(ux);
         v2y_ff    <= DW'(point_y) - DW'(uy);
         fx_ff     <= DW'(point_x) - DW'(dx);
         fy_ff     <= DW'(point_y) - DW'(dy);
         prior1_ff <= prior_in;
      end
   end

   // Stage 2: one rank of multipliers
   always_ff @(posedge clock) begin
      if (enable) begin
         c0_ff     <= v0x_ff * v1y_ff;
         c1_ff     <= v0y_ff * v1x_ff;
         wd0_ff    <= v2x_ff * v1y_ff;
         wd1_ff    <= v2y_ff * v1x_ff;
         wb0_ff    <= v0x_ff * v2y_ff;
         wb1_ff    <= v0y_ff * v2x_ff;
         nud0_ff   <= v2x_ff * v0x_ff;
         nud1_ff   <= v2y_ff * v0y_ff;
         lud0_ff   <= v0x_ff * v0x_ff;
         lud1_ff   <= v0y_ff * v0y_ff;
         nub0_ff   <= v2x_ff * v1x_ff;
         nub1_ff   <= v2y_ff * v1y_ff;
         lub0_ff   <= v1x_ff * v1x_ff;
         lub1_ff   <= v1y_ff * v1y_ff;
         ndb0_ff   <= fx_ff * ex_ff;
         ndb1_ff   <= fy_ff * ey_ff;
         ldb0_ff   <= ex_ff * ex_ff;
         ldb1_ff   <= ey_ff * ey_ff;
         prior2_ff <= prior1_ff;
      end
   end

   // Stage 3: pair the products
   always_comb begin
      sums_in.c     = SW'(c0_ff) - SW'(c1_ff);
      sums_in.wd    = SW'(wd0_ff) - SW'(wd1_ff);
      sums_in.wb    = SW'(wb0_ff) - SW'(wb1_ff);
      sums_in.n_ud  = SW'(nud0_ff) + SW'(nud1_ff);
      sums_in.l_ud  = SW'(lud0_ff) + SW'(lud1_ff);
      sums_in.n_ub  = SW'(nub0_ff) + SW'(nub1_ff);
      sums_in.l_ub  = SW'(lub0_ff) + SW'(lub1_ff);
      sums_in.n_db  = SW'(ndb0_ff) + SW'(ndb1_ff);
      sums_in.l_db  = SW'(ldb0_ff) + SW'(ldb1_ff);
      sums_in.prior = prior2_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sums_ff <= sums_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_sums  = sums_ff;

endmodule

// ----- rtl/core/potri_select.sv -----
// Two-stage region decision: orient, inside test, nearest edge or corner.
// Depends on potri_pkg.
module potri_select (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  potri_pkg::potri_sums_type in_sums,
   output logic                      out_valid,
   output potri_pkg::potri_frac_type out_frac
);
   localparam int SW = potri_pkg::SUM_W;
   localparam int WW = potri_pkg::WU_W;
   localparam int NW = potri_pkg::DEN_W;

   logic v4_ff, v5_ff;
   logic deg_ff, deg_in;
   logic signed [SW-1:0] c_ff, wd_ff, wb_ff, c_in, wd_in, wb_in;
   logic signed [WW-1:0] wu_ff, wu_in;
   potri_pkg::potri_sums_type s4_ff;
   potri_pkg::potri_frac_type frac_ff, frac_in;
   logic signed [SW-1:0] ldb_minus_ndb;

   // Stage 4: make the triangle counterclockwise, form the third weight
   always_comb begin
      deg_in = (in_sums.c == '0);
      if (in_sums.c < 0) begin
         c_in  = -in_sums.c;
         wd_in = -in_sums.wd;
         wb_in = -in_sums.wb;
      end else begin
         c_in  = in_sums.c;
         wd_in = in_sums.wd;
         wb_in = in_sums.wb;
      end
      wu_in = WW'(c_in) - WW'(wd_in) - WW'(wb_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (enable) begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         deg_ff <= deg_in;
         c_ff   <= c_in;
         wd_ff  <= wd_in;
         wb_ff  <= wb_in;
         wu_ff  <= wu_in;
         s4_ff  <= in_sums;
      end
   end

   assign ldb_minus_ndb = s4_ff.l_db - s4_ff.n_db;

   // Stage 5: pick the numerators and the denominator
   always_comb begin
      frac_in.bn    = '0;
      frac_in.dn    = '0;
      frac_in.den   = NW'(1);
      frac_in.prior = s4_ff.prior;
      if (!deg_ff) begin
         if (wd_ff >= 0 && wb_ff >= 0 && wu_ff >= 0) begin
            frac_in.bn  = wb_ff[NW-1:0];
            frac_in.dn  = wd_ff[NW-1:0];
            frac_in.den = c_ff[NW-1:0];
         end else if (wb_ff < 0 && s4_ff.n_ud > 0 && s4_ff.n_ud < s4_ff.l_ud) begin
            frac_in.dn  = s4_ff.n_ud[NW-1:0];
            frac_in.den = s4_ff.l_ud[NW-1:0];
         end else if (wd_ff < 0 && s4_ff.n_ub > 0 && s4_ff.n_ub < s4_ff.l_ub) begin
            frac_in.bn  = s4_ff.n_ub[NW-1:0];
            frac_in.den = s4_ff.l_ub[NW-1:0];
         end else if (wu_ff < 0 && s4_ff.n_db > 0 && s4_ff.n_db < s4_ff.l_db) begin
            frac_in.bn  = s4_ff.n_db[NW-1:0];
            frac_in.dn  = ldb_minus_ndb[NW-1:0];
            frac_in.den = s4_ff.l_db[NW-1:0];
         end else if (s4_ff.n_ud <= 0 && s4_ff.n_ub <= 0) begin
            // uncertainty corner: both weights zero
            frac_in.bn = '0;
         end else if (s4_ff.n_ud >= s4_ff.l_ud && s4_ff.n_db <= 0) begin
            frac_in.dn = NW'(1);
         end else begin
            frac_in.bn = NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         frac_ff <= frac_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_frac  = frac_ff;

endmodule

// ----- rtl/core/potri_div.sv -----
// Pipelined restoring divider: one quotient bit per stage for belief and
// disbelief over a shared denominator. Depends on potri_pkg.
module potri_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  potri_pkg::potri_frac_type in_frac,
   output logic                      out_valid,
   output potri_pkg::potri_div_type  out_div
);
   localparam int NS = potri_pkg::DIV_STAGES;
   localparam int RW = potri_pkg::REM_W;
   localparam int QW = potri_pkg::Q_W;

   potri_pkg::potri_div_type stage_ff [NS];
   potri_pkg::potri_div_type stage_in [NS];
   logic [NS-1:0] valid_ff;

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[NS-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic [RW-1:0] tb, td, dw;

      // First stage compares the numerator itself, later ones the doubled remainder
      always_comb begin
         dw = RW'(k == 0 ? in_frac.den : stage_ff[(k == 0) ? 0 : k-1].den);
         if (k == 0) begin
            tb = RW'(in_frac.bn);
            td = RW'(in_frac.dn);
            stage_in[k].qb    = '0;
            stage_in[k].qd    = '0;
            stage_in[k].den   = in_frac.den;
            stage_in[k].prior = in_frac.prior;
         end else begin
            tb = stage_ff[(k == 0) ? 0 : k-1].rb << 1;
            td = stage_ff[(k == 0) ? 0 : k-1].rd << 1;
            stage_in[k].qb    = stage_ff[(k == 0) ? 0 : k-1].qb;
            stage_in[k].qd    = stage_ff[(k == 0) ? 0 : k-1].qd;
            stage_in[k].den   = stage_ff[(k == 0) ? 0 : k-1].den;
            stage_in[k].prior = stage_ff[(k == 0) ? 0 : k-1].prior;
         end
         stage_in[k].rb = (tb >= dw) ? tb - dw : tb;
         stage_in[k].rd = (td >= dw) ? td - dw : td;
         stage_in[k].qb = {stage_in[k].qb[QW-2:0], (tb >= dw)};
         stage_in[k].qd = {stage_in[k].qd[QW-2:0], (td >= dw)};
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_div   = stage_ff[NS-1];

endmodule

// ----- rtl/core/point_to_opinion_triangle_unit.sv -----
// Point to opinion triangle unit: maps a query point onto belief, disbelief
// and uncertainty over the triangle spanned by three programmed corners.
// One word is accepted per clock; a result passes three geometry stages, two
// decision stages, sixteen divider stages and one output register. The divider
// retires one quotient bit per stage. The whole pipe holds while a result waits
// with rsp_stall high, so req_stall rises only then. Write corners only while no
// word is in flight.
module point_to_opinion_triangle_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [potri_pkg::COORD_BITS-1:0] req_point_x,
   input  logic signed [potri_pkg::COORD_BITS-1:0] req_point_y,
   input  logic [potri_pkg::FIELD_W-1:0]          req_prior_rate,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [potri_pkg::FIELD_W-1:0]          rsp_belief_weight,
   output logic [potri_pkg::FIELD_W-1:0]          rsp_disbelief_weight,
   output logic [potri_pkg::FIELD_W-1:0]          rsp_uncert_weight,
   output logic [potri_pkg::FIELD_W-1:0]          rsp_prior_out,
   input  logic                                   csr_write,
   input  logic [potri_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [potri_pkg::COORD_BITS-1:0]       csr_wdata
);
   localparam int CB = potri_pkg::COORD_BITS;
   localparam int FW = potri_pkg::FIELD_W;
   localparam int QW = potri_pkg::Q_W;

   logic signed [CB-1:0] ux_ff, uy_ff, dx_ff, dy_ff, bx_ff, by_ff;
   logic enable;
   logic geom_valid, sel_valid, div_valid;
   potri_pkg::potri_sums_type sums;
   potri_pkg::potri_frac_type frac;
   potri_pkg::potri_div_type  dres;
   logic rsp_valid_ff;
   logic [FW-1:0] bel_ff, dis_ff, unc_ff, pri_ff;

   // Move the pipe unless a finished word is held
   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;

   // Corner registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ux_ff <= CB'(512);
         uy_ff <= '0;
         dx_ff <= '0;
         dy_ff <= CB'(887);
         bx_ff <= CB'(1024);
         by_ff <= CB'(887);
      end else if (csr_write) begin
         case (csr_index)
            potri_pkg::CSR_UNCERT_X:    ux_ff <= csr_wdata;
            potri_pkg::CSR_UNCERT_Y:    uy_ff <= csr_wdata;
            potri_pkg::CSR_DISBELIEF_X: dx_ff <= csr_wdata;
            potri_pkg::CSR_DISBELIEF_Y: dy_ff <= csr_wdata;
            potri_pkg::CSR_BELIEF_X:    bx_ff <= csr_wdata;
            potri_pkg::CSR_BELIEF_Y:    by_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   potri_geom u_geom (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (req_valid),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .prior_rate (req_prior_rate),
      .ux         (ux_ff),
      .uy         (uy_ff),
      .dx         (dx_ff),
      .dy         (dy_ff),
      .bx         (bx_ff),
      .by         (by_ff),
      .out_valid  (geom_valid),
      .out_sums   (sums)
   );

   potri_select u_select (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (geom_valid),
      .in_sums   (sums),
      .out_valid (sel_valid),
      .out_frac  (frac)
   );

   potri_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (sel_valid),
      .in_frac   (frac),
      .out_valid (div_valid),
      .out_div   (dres)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         bel_ff <= FW'(dres.qb);
         dis_ff <= FW'(dres.qd);
         unc_ff <= potri_pkg::ONE_Q - FW'(dres.qb) - FW'(dres.qd);
         pri_ff <= dres.prior;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_belief_weight    = bel_ff;
   assign rsp_disbelief_weight = dis_ff;
   assign rsp_uncert_weight    = unc_ff;
   assign rsp_prior_out        = pri_ff;

   // The three weights of a word always make up exactly one
   a_sum_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((FW+2)'(bel_ff) + (FW+2)'(dis_ff) + (FW+2)'(unc_ff))
                       == (FW+2)'(potri_pkg::ONE_Q))
      else $error("weights do not sum to one");

   // Quotients never exceed one
   a_q_range: assert property (@(posedge clock) disable iff (reset)
      div_valid |-> (dres.qb <= QW'(potri_pkg::ONE_Q) && dres.qd <= QW'(potri_pkg::ONE_Q)))
      else $error("quotient above one");

   // The divider never sees a zero denominator or a numerator above it
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      sel_valid |-> (frac.den != '0 && frac.bn <= frac.den && frac.dn <= frac.den))
      else $error("bad divider operands");

   // Clamped base rate stays within one
   a_prior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (pri_ff <= potri_pkg::ONE_Q))
      else $error("base rate above one");

endmodule

// ----- bench/point_to_opinion_triangle_unit_test.sv -----
// Testbench for the point to opinion triangle unit: a directed table, then random
// points over several corner settings, each result checked against a typed row or a
// local predictor. Depends on potri_pkg and point_to_opinion_triangle_unit.
`timescale 1ns / 1ps

module point_to_opinion_triangle_unit_test;
   import potri_pkg::*;

   localparam int LATENCY     = 22;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [15:0] belief;
      logic [15:0] disbelief;
      logic [15:0] uncert;
      logic [15:0] prior;
   } opinion_type;

   typedef struct {
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic [15:0]        rate;
      bit                 typed;
      opinion_type        want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_point_x = '0;
   logic signed [15:0] req_point_y = '0;
   logic [15:0] req_prior_rate = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_belief_weight, rsp_disbelief_weight, rsp_uncert_weight, rsp_prior_out;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // corner copy: u, d, b as x/y pairs
   longint corner_x [3];
   longint corner_y [3];

   opinion_type opinion_queue [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   point_to_opinion_triangle_unit dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** point_to_opinion_triangle_unit: FAILED **");
         $finish;
      end
   end

   // floor(2^15 * n / l), 0 <= n <= l
   function automatic logic [15:0] frac_quotient(longint n, longint l);
      if (l == 0) return '0;
      return 16'((n <<< FRAC_BITS) / l);
   endfunction

   function automatic opinion_type predict_opinion(logic signed [15:0] px_in,
                                                   logic signed [15:0] py_in,
                                                   logic [15:0] rate);
      opinion_type o;
      longint px, py, v0x, v0y, v1x, v1y, v2x, v2y, c, wd, wb, wu;
      longint ex, ey, fx, fy, n_ud, l_ud, n_ub, l_ub, n_db, l_db;
      longint bn, dn, den;
      px = px_in; py = py_in;
      v0x = corner_x[1] - corner_x[0]; v0y = corner_y[1] - corner_y[0];
      v1x = corner_x[2] - corner_x[0]; v1y = corner_y[2] - corner_y[0];
      v2x = px - corner_x[0]; v2y = py - corner_y[0];
      c = v0x * v1y - v0y * v1x;
      wd = v2x * v1y - v2y * v1x;
      wb = v0x * v2y - v0y * v2x;
      bn = 0; dn = 0; den = 1;
      if (c != 0) begin
         if (c < 0) begin
            c = -c; wd = -wd; wb = -wb;
         end
         wu = c - wd - wb;
         if (wd >= 0 && wb >= 0 && wu >= 0) begin
            bn = wb; dn = wd; den = c;
         end else begin
            ex = corner_x[2] - corner_x[1]; ey = corner_y[2] - corner_y[1];
            fx = px - corner_x[1]; fy = py - corner_y[1];
            n_ud = v2x * v0x + v2y * v0y; l_ud = v0x * v0x + v0y * v0y;
            n_ub = v2x * v1x + v2y * v1y; l_ub = v1x * v1x + v1y * v1y;
            n_db = fx * ex + fy * ey;     l_db = ex * ex + ey * ey;
            if (wb < 0 && n_ud > 0 && n_ud < l_ud) begin
               dn = n_ud; den = l_ud;
            end else if (wd < 0 && n_ub > 0 && n_ub < l_ub) begin
               bn = n_ub; den = l_ub;
            end else if (wu < 0 && n_db > 0 && n_db < l_db) begin
               bn = n_db; dn = l_db - n_db; den = l_db;
            end else if (n_ud <= 0 && n_ub <= 0) begin
               // nearest to the uncertainty corner
            end else if (n_ud >= l_ud && n_db <= 0) begin
               dn = 1;
            end else begin
               bn = 1;
            end
         end
      end
      o.belief = frac_quotient(bn, den);
      o.disbelief = frac_quotient(dn, den);
      o.uncert = ONE_Q - o.belief - o.disbelief;
      o.prior = (rate > ONE_Q) ? ONE_Q : rate;
      return o;
   endfunction

   // write one corner register while the pipe is empty
   task automatic write_corner(csr_index_type idx, logic signed [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_UNCERT_X:    corner_x[0] = value;
         CSR_UNCERT_Y:    corner_y[0] = value;
         CSR_DISBELIEF_X: corner_x[1] = value;
         CSR_DISBELIEF_Y: corner_y[1] = value;
         CSR_BELIEF_X:    corner_x[2] = value;
         default:         corner_y[2] = value;
      endcase
   endtask

   task automatic set_corners(logic signed [15:0] ux, uy, dx, dy, bx, by);
      write_corner(CSR_UNCERT_X, ux);
      write_corner(CSR_UNCERT_Y, uy);
      write_corner(CSR_DISBELIEF_X, dx);
      write_corner(CSR_DISBELIEF_Y, dy);
      write_corner(CSR_BELIEF_X, bx);
      write_corner(CSR_BELIEF_Y, by);
      csr_write <= 1'b0;
   endtask

   // send one word, holding it until accepted; expectation is queued on acceptance.
   // Valid stays high afterwards so the next word can follow in the next cycle.
   task automatic send_point(logic signed [15:0] px, py, logic [15:0] rate,
                             bit typed, opinion_type want);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      req_prior_rate <= rate;
      do @(posedge clock); while (req_stall);
      if (typed) opinion_queue.push_back(want);
      else opinion_queue.push_back(predict_opinion(px, py, rate));
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (opinion_queue.size() > 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
   end

   // compare each accepted word against the oldest expectation
   always @(posedge clock) begin
      opinion_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (opinion_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result word");
         end else begin
            want = opinion_queue.pop_front();
            if (rsp_belief_weight !== want.belief || rsp_disbelief_weight !== want.disbelief
                || rsp_uncert_weight !== want.uncert || rsp_prior_out !== want.prior) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: want b=%0d d=%0d u=%0d p=%0d got b=%0d d=%0d u=%0d p=%0d",
                           want.belief, want.disbelief, want.uncert, want.prior,
                           rsp_belief_weight, rsp_disbelief_weight, rsp_uncert_weight,
                           rsp_prior_out);
            end
         end
      end
   end

   function automatic logic signed [15:0] random_coord(int span);
      if (span == 0) return 16'($urandom);
      return 16'($urandom_range(2 * span, 0) - span);
   endfunction

   function automatic logic [15:0] random_rate();
      return ($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'($urandom_range(32768, 0));
   endfunction

   stim_row_type stim_table [$];

   initial begin
      stim_row_type row;
      int phase, span;
      logic signed [15:0] px, py;
      opinion_type o;
      corner_x = '{512, 0, 1024};
      corner_y = '{0, 887, 887};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table on the reset corners: corners, edges, outside, prior extremes
      stim_table = '{
         '{16'sd512, 16'sd0, 16'd0, 1'b1, '{16'd0, 16'd0, 16'd32768, 16'd0}},
         '{16'sd0, 16'sd887, 16'd32768, 1'b1, '{16'd0, 16'd32768, 16'd0, 16'd32768}},
         '{16'sd1024, 16'sd887, 16'd65535, 1'b1, '{16'd32768, 16'd0, 16'd0, 16'd32768}},
         '{16'sd512, -16'sd32768, 16'd32769, 1'b1, '{16'd0, 16'd0, 16'd32768, 16'd32768}},
         '{16'sd512, 16'sd887, 16'd16384, 1'b0, '{default: '0}},
         '{16'sd512, 16'sd400, 16'd1, 1'b0, '{default: '0}},
         '{-16'sd32768, -16'sd32768, 16'd100, 1'b0, '{default: '0}},
         '{16'sd32767, 16'sd32767, 16'd32767, 1'b0, '{default: '0}},
         '{-16'sd32768, 16'sd32767, 16'd0, 1'b0, '{default: '0}},
         '{16'sd32767, -16'sd32768, 16'd0, 1'b0, '{default: '0}},
         '{16'sd512, 16'sd32767, 16'd0, 1'b0, '{default: '0}},
         '{16'sd256, 16'sd443, 16'd0, 1'b0, '{default: '0}},
         '{16'sd1000, 16'sd100, 16'd0, 1'b0, '{default: '0}},
         '{-16'sd5, 16'sd0, 16'd0, 1'b0, '{default: '0}},
         '{16'sd2000, 16'sd900, 16'd0, 1'b0, '{default: '0}},
         '{-16'sd1, -16'sd1, 16'd43690, 1'b0, '{default: '0}}
      };
      foreach (stim_table[i])
         send_point(stim_table[i].px, stim_table[i].py, stim_table[i].rate,
                    stim_table[i].typed, stim_table[i].want);
      drain_pipe();

      // degenerate triangle: pure uncertainty regardless of the point
      set_corners(16'sd0, 16'sd0, 16'sd100, 16'sd100, 16'sd200, 16'sd200);
      o = '{16'd0, 16'd0, 16'd32768, 16'd5};
      send_point(16'sd50, -16'sd7, 16'd5, 1'b1, o);
      send_point(16'sd32767, 16'sd32767, 16'd5, 1'b1, o);
      drain_pipe();

      // random phases over corner settings and idling patterns
      for (phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 51; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 51; end
            default: begin send_idle_pct = 12; stall_pct = 12; end
         endcase
         case (phase)
            0: set_corners(16'sd512, 16'sd0, 16'sd0, 16'sd887, 16'sd1024, 16'sd887);
            1: set_corners(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768,
                           -16'sd32768, 16'sd32767);
            2: set_corners(16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767,
                           16'sd32767, -16'sd32768);
            3: set_corners(16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd3);
            default: set_corners(random_coord(0), random_coord(0), random_coord(0),
                                 random_coord(0), random_coord(0), random_coord(0));
         endcase
         span = (phase == 3) ? 8 : 0;
         for (int k = 0; k < 100; k++) begin
            if ($urandom_range(1, 0) == 0) begin
               // aim near the triangle so inside and edge cases are common
               px = 16'((corner_x[$urandom_range(2, 0)] + corner_x[$urandom_range(2, 0)]) / 2
                        + $signed(random_coord(phase == 3 ? 4 : 64)));
               py = 16'((corner_y[$urandom_range(2, 0)] + corner_y[$urandom_range(2, 0)]) / 2
                        + $signed(random_coord(phase == 3 ? 4 : 64)));
            end else begin
               px = random_coord(span);
               py = random_coord(span);
            end
            send_point(px, py, random_rate(), 1'b0, o);
            // let the pipe drain completely once
            if (phase == 1 && k == 50) begin
               req_valid <= 1'b0;
               while (opinion_queue.size() > 0) @(posedge clock);
            end
         end
         drain_pipe();
      end

      send_idle_pct = 0;
      stall_pct = 0;
      drain_pipe();
      if (mismatch_count == 0 && opinion_queue.size() == 0) begin
         $display("** point_to_opinion_triangle_unit: PASSED **");
      end else begin
         $display("** point_to_opinion_triangle_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ----- point_to_opinion_triangle_unit.f -----
rtl/core/potri_pkg.sv
rtl/core/potri_geom.sv
rtl/core/potri_select.sv
rtl/core/potri_div.sv
rtl/core/point_to_opinion_triangle_unit.sv
bench/point_to_opinion_triangle_unit_test.sv
